// File: hw/rtl/png_unf_pkg.sv
// Shared types, codes and helper functions for the PNG scanline unfilter.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package png_unf_pkg;

  // Fixed field widths.
  localparam int BYTE_POS_W  = 12;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 16;
  localparam int WIDTH_REG_W = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_PAD_W   = 6;

  // Output queue geometry.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  localparam logic [BYTE_POS_W-1:0] POS_LAST = 12'hfff;
  localparam logic [7:0]            ALPHA_OPAQUE = 8'hff;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLOR_MODE   = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_TRANSPARENCY = 2'd3
  } cfg_reg_t;

  // Colour modes; any other code is handled as RGBA.
  localparam logic [1:0] MODE_PALETTE = 2'd0;
  localparam logic [1:0] MODE_RGB     = 2'd1;

  // Input word kinds carried on tuser.
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  // Filter codes.
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             unsupported;
    logic             last;
    logic [1:0]       mode;
    logic             transp;
  } pix_info_t;

  // One stream byte on its way from the counters to the reconstruction stage.
  typedef struct packed {
    logic       valid;
    logic       is_filter;
    logic [7:0] raw;
    logic [1:0] lane;
    logic       row_zero;
    logic [7:0] filter;
    logic       pix_done;
    pix_info_t  info;
  } byte_stage_t;

  // A completed pixel waiting for its palette lookup.
  typedef struct packed {
    logic        valid;
    logic [31:0] assembly;
    pix_info_t   info;
  } pix_stage_t;

  typedef struct packed {
    logic                   we;
    logic [7:0]             index;
    logic [23:0]            color;
    logic [7:0]             alpha;
  } pal_write_t;

  typedef struct packed {
    logic [OUT_TDATA_W-1:0] tdata;
    logic                   tuser;
    logic                   tlast;
  } out_word_t;

  // Paeth predictor on unsigned bytes.
  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic [7:0] pa;
    logic [7:0] pb;
    logic [8:0] sum;
    logic [8:0] cc;
    logic [8:0] pc;
    pa  = (b >= c) ? b - c : c - b;
    pb  = (a >= c) ? a - c : c - a;
    sum = {1'b0, a} + {1'b0, b};
    cc  = {c, 1'b0};
    pc  = (sum >= cc) ? sum - cc : cc - sum;
    if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
      paeth_pred = a;
    end else if ({1'b0, pb} <= pc) begin
      paeth_pred = b;
    end else begin
      paeth_pred = c;
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/png_unf_ctrl.sv
// Configuration registers and stream counters for the PNG scanline unfilter.
// Issues prior-row store reads and registers each accepted data byte; uses png_unf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module png_unf_ctrl #(
  parameter int MAX_WIDTH = 1024,
  localparam int STORE_DEPTH = 4 * MAX_WIDTH,
  localparam int ADDR_W = $clog2(STORE_DEPTH)
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [png_unf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [png_unf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                                  accept,
  input  wire                                  op,
  input  wire  [7:0]                           data_byte,
  output logic                                 rd_en,
  output logic [ADDR_W-1:0]                    rd_addr,
  output png_unf_pkg::byte_stage_t             stage_q,
  output logic [ADDR_W-1:0]                    stage_addr
);

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [15:0]       MAX_W16   = 16'(MAX_WIDTH);

  logic [1:0]                                color_mode;
  logic [png_unf_pkg::WIDTH_REG_W-1:0]       image_width;
  logic [png_unf_pkg::ROW_W-1:0]             image_height;
  logic                                      transparency;

  logic [png_unf_pkg::BYTE_POS_W-1:0] pos, pos_next;
  logic [ADDR_W-1:0]                  addr, addr_next;
  logic [10:0]                        q3, q3_next;
  logic [1:0]                         r3, r3_next;
  logic [1:0]                         bip, bip_next;
  logic [png_unf_pkg::ROW_W-1:0]      row, row_next;
  logic [7:0]                         filter, filter_next;
  logic                               awaiting, awaiting_next;

  logic        take_data, take_filter, take_byte;
  logic [2:0]  bpp;
  logic [1:0]  bip_inc;
  logic        pix_done;
  logic [11:0] col;
  logic [15:0] width_eff;
  logic [15:0] height_eff;
  logic        end_row, last_row;
  png_unf_pkg::byte_stage_t stage_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= png_unf_pkg::MODE_PALETTE;
      image_width  <= 11'd1;
      image_height <= 16'd1;
      transparency <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        png_unf_pkg::REG_COLOR_MODE:   color_mode   <= cfg_data[1:0];
        png_unf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[png_unf_pkg::WIDTH_REG_W-1:0];
        png_unf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        png_unf_pkg::REG_TRANSPARENCY: transparency <= cfg_data[0];
        default:                       color_mode   <= color_mode;
      endcase
    end
  end

  assign take_data   = accept && (op == png_unf_pkg::OP_DATA);
  assign take_filter = take_data && awaiting;
  assign take_byte   = take_data && !awaiting;

  always_comb begin
    if (color_mode == png_unf_pkg::MODE_PALETTE) begin
      bpp = 3'd1;
      col = pos;
    end else if (color_mode == png_unf_pkg::MODE_RGB) begin
      bpp = 3'd3;
      col = {1'b0, q3};
    end else begin
      bpp = 3'd4;
      col = {2'b00, pos[11:2]};
    end
  end

  assign bip_inc  = bip + 2'd1;
  assign pix_done = (bip_inc == 2'd0) || ({1'b0, bip_inc} >= bpp);

  always_comb begin
    width_eff = {5'b0, image_width};
    if (width_eff == 16'd0) begin
      width_eff = 16'd1;
    end else if (width_eff > MAX_W16) begin
      width_eff = MAX_W16;
    end
  end

  assign height_eff = (image_height == 16'd0) ? 16'd1 : image_height;
  assign end_row    = ({4'b0, col} + 16'd1) >= width_eff;
  assign last_row   = ({1'b0, row} + 17'd1) >= {1'b0, height_eff};

  assign rd_en   = take_byte;
  assign rd_addr = addr;

  always_comb begin
    pos_next      = pos;
    addr_next     = addr;
    q3_next       = q3;
    r3_next       = r3;
    bip_next      = bip;
    row_next      = row;
    filter_next   = filter;
    awaiting_next = awaiting;
    if (take_filter) begin
      filter_next   = data_byte;
      awaiting_next = 1'b0;
      pos_next      = '0;
      addr_next     = '0;
      q3_next       = '0;
      r3_next       = '0;
      bip_next      = '0;
    end else if (take_byte) begin
      pos_next = pos + 12'd1;
      if (pos == png_unf_pkg::POS_LAST) begin
        addr_next = '0;
        q3_next   = '0;
        r3_next   = '0;
      end else begin
        addr_next = (addr == ADDR_LAST) ? '0 : addr + ADDR_W'(1);
        if (r3 == 2'd2) begin
          r3_next = 2'd0;
          q3_next = q3 + 11'd1;
        end else begin
          r3_next = r3 + 2'd1;
        end
      end
      bip_next = pix_done ? 2'd0 : bip_inc;
      if (pix_done && end_row) begin
        awaiting_next = 1'b1;
        row_next      = last_row ? '0 : row + 16'd1;
      end
    end
  end

  always_comb begin
    stage_next.valid            = take_data;
    stage_next.is_filter        = awaiting;
    stage_next.raw              = data_byte;
    stage_next.lane             = bip;
    stage_next.row_zero         = (row == '0);
    stage_next.filter           = filter;
    stage_next.pix_done         = take_byte && pix_done;
    stage_next.info.col         = col[png_unf_pkg::COL_W-1:0];
    stage_next.info.row         = row;
    stage_next.info.unsupported = filter > png_unf_pkg::FILT_PAETH;
    stage_next.info.last        = end_row && last_row;
    stage_next.info.mode        = color_mode;
    stage_next.info.transp      = transparency;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      addr     <= '0;
      q3       <= '0;
      r3       <= '0;
      bip      <= '0;
      row      <= '0;
      filter   <= '0;
      awaiting <= 1'b1;
      stage_q  <= '0;
    end else begin
      pos      <= pos_next;
      addr     <= addr_next;
      q3       <= q3_next;
      r3       <= r3_next;
      bip      <= bip_next;
      row      <= row_next;
      filter   <= filter_next;
      awaiting <= awaiting_next;
      stage_q  <= stage_next;
    end
  end

  always_ff @(posedge clk) begin
    stage_addr <= addr;
  end

`ifndef SYNTHESIS
  // The byte that closes a row must leave the counters waiting for a filter code.
  a_row_end_waits: assert property (@(posedge clk) disable iff (rst)
    (take_byte && pix_done && end_row) |=> awaiting)
    else $error("row end did not arm the filter code wait");

  // A filter code restarts the row at byte zero, lane zero.
  a_filter_restarts: assert property (@(posedge clk) disable iff (rst)
    take_filter |=> (pos == '0) && (bip == 2'd0) && (addr == '0))
    else $error("filter code did not restart the row counters");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/png_unf_recon.sv
// Prior-row store and per-byte filter reconstruction for the PNG unfilter.
// Reads the byte above, undoes the filter and writes the result back; uses png_unf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module png_unf_recon #(
  parameter int MAX_WIDTH = 1024,
  localparam int STORE_DEPTH = 4 * MAX_WIDTH,
  localparam int ADDR_W = $clog2(STORE_DEPTH)
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            rd_en,
  input  wire  [ADDR_W-1:0]              rd_addr,
  input  png_unf_pkg::byte_stage_t       stage,
  input  wire  [ADDR_W-1:0]              stage_addr,
  output png_unf_pkg::pix_stage_t        pix_q,
  output logic                           pal_rd_en,
  output logic [7:0]                     pal_rd_index
);

  logic [7:0] store [STORE_DEPTH];
  logic [7:0] store_q;

  logic [3:0][7:0] left;
  logic [3:0][7:0] above;
  logic [3:0][7:0] asm_bytes;
  logic [3:0][7:0] asm_new;

  logic [7:0] a, b, c;
  logic [8:0] sum_ab;
  logic [7:0] pred;
  logic [7:0] rec;
  logic       wr_en;

  assign wr_en = stage.valid && !stage.is_filter;

  // Same-cycle read of the entry being written returns the new byte.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[stage_addr] <= rec;
    end
    if (rd_en) begin
      store_q <= (wr_en && (stage_addr == rd_addr)) ? rec : store[rd_addr];
    end
  end

  assign a      = left[stage.lane];
  assign b      = stage.row_zero ? 8'd0 : store_q;
  assign c      = above[stage.lane];
  assign sum_ab = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (stage.filter)
      png_unf_pkg::FILT_NONE:  pred = 8'd0;
      png_unf_pkg::FILT_SUB:   pred = a;
      png_unf_pkg::FILT_UP:    pred = b;
      png_unf_pkg::FILT_AVG:   pred = sum_ab[8:1];
      png_unf_pkg::FILT_PAETH: pred = png_unf_pkg::paeth_pred(a, b, c);
      default:                 pred = 8'd0;
    endcase
  end

  assign rec = stage.raw + pred;

  always_comb begin
    asm_new             = asm_bytes;
    asm_new[stage.lane] = rec;
  end

  always_ff @(posedge clk) begin
    if (stage.valid) begin
      if (stage.is_filter) begin
        left      <= '0;
        above     <= '0;
        asm_bytes <= '0;
      end else begin
        left[stage.lane]  <= rec;
        above[stage.lane] <= b;
        asm_bytes         <= stage.pix_done ? '0 : asm_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_q <= '0;
    end else begin
      pix_q.valid    <= wr_en && stage.pix_done;
      pix_q.assembly <= asm_new;
      pix_q.info     <= stage.info;
    end
  end

  assign pal_rd_en    = wr_en && stage.pix_done;
  assign pal_rd_index = asm_new[0];

`ifndef SYNTHESIS
  // Consecutive data bytes never share a store entry, so the bypass stays idle.
  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != stage_addr))
    else $error("prior-row read and write hit the same entry");

  // In palette mode each byte is a whole pixel in lane zero.
  a_palette_lane: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (stage.info.mode == png_unf_pkg::MODE_PALETTE))
      |-> ((stage.lane == 2'd0) && stage.pix_done))
    else $error("palette byte left lane zero");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/png_unf_palette.sv
// Palette colour and alpha memories and final RGBA assembly for the PNG unfilter.
// Produces one output word per completed pixel; uses png_unf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module png_unf_palette (
  input  wire                          clk,
  input  wire                          rst,
  input  png_unf_pkg::pal_write_t      pal_wr,
  input  wire                          rd_en,
  input  wire  [7:0]                   rd_index,
  input  png_unf_pkg::pix_stage_t      pix,
  output logic                         push,
  output png_unf_pkg::out_word_t       push_word
);

  logic [23:0] colors [256];
  logic [7:0]  alphas [256];
  logic [255:0] alpha_valid;

  logic [23:0] color_q;
  logic [7:0]  alpha_q;
  logic        alpha_valid_q;

  logic [7:0] alpha_lut;
  logic [7:0] red, green, blue, alpha;

  always_ff @(posedge clk) begin
    if (pal_wr.we) begin
      colors[pal_wr.index] <= pal_wr.color;
      alphas[pal_wr.index] <= pal_wr.alpha;
    end
    if (rd_en) begin
      color_q <= colors[rd_index];
      alpha_q <= alphas[rd_index];
    end
  end

  // Entries never written read back as opaque.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_valid   <= '0;
      alpha_valid_q <= 1'b0;
    end else begin
      if (pal_wr.we) begin
        alpha_valid[pal_wr.index] <= 1'b1;
      end
      if (rd_en) begin
        alpha_valid_q <= alpha_valid[rd_index];
      end
    end
  end

  assign alpha_lut = alpha_valid_q ? alpha_q : png_unf_pkg::ALPHA_OPAQUE;

  always_comb begin
    case (pix.info.mode)
      png_unf_pkg::MODE_PALETTE: begin
        red   = color_q[7:0];
        green = color_q[15:8];
        blue  = color_q[23:16];
        alpha = pix.info.transp ? alpha_lut : png_unf_pkg::ALPHA_OPAQUE;
      end
      png_unf_pkg::MODE_RGB: begin
        red   = pix.assembly[7:0];
        green = pix.assembly[15:8];
        blue  = pix.assembly[23:16];
        alpha = png_unf_pkg::ALPHA_OPAQUE;
      end
      default: begin
        red   = pix.assembly[7:0];
        green = pix.assembly[15:8];
        blue  = pix.assembly[23:16];
        alpha = pix.assembly[31:24];
      end
    endcase
  end

  assign push            = pix.valid;
  assign push_word.tdata = {{png_unf_pkg::OUT_PAD_W{1'b0}}, pix.info.row, pix.info.col,
                            alpha, blue, green, red};
  assign push_word.tuser = pix.info.unsupported;
  assign push_word.tlast = pix.info.last;

endmodule

`default_nettype wire

// File: hw/rtl/png_unf_outq.sv
// Small output queue that decouples the pixel pipeline from the result stream.
// Holds finished output words until the consumer takes them; uses png_unf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module png_unf_outq (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   push,
  input  png_unf_pkg::out_word_t                push_word,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [png_unf_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                                  m_tuser,
  output logic                                  m_tlast,
  output logic [png_unf_pkg::OUTQ_CNT_W-1:0]    count
);

  localparam logic [png_unf_pkg::OUTQ_CNT_W-1:0] FULL =
    png_unf_pkg::OUTQ_CNT_W'(png_unf_pkg::OUTQ_DEPTH);

  png_unf_pkg::out_word_t entries [png_unf_pkg::OUTQ_DEPTH];
  logic [png_unf_pkg::OUTQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic pop;

  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = entries[rd_ptr].tdata;
  assign m_tuser  = entries[rd_ptr].tuser;
  assign m_tlast  = entries[rd_ptr].tlast;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + png_unf_pkg::OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + png_unf_pkg::OUTQ_PTR_W'(1);
      end
      count <= count + png_unf_pkg::OUTQ_CNT_W'(push) - png_unf_pkg::OUTQ_CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  // Input credit must keep a slot free for every pixel already in flight.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && (count == FULL) && !pop))
    else $error("output queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("output queue count out of range");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/png_scanline_unfilter_top.sv
// A pixel-completing byte passes stage_q, pix_q and the output queue before m_tdata.
// Throughput: one stream word per cycle while s_tready is high; the prior-row store takes
// one read and one write each cycle, and input credit follows the four-word output queue.
// Reset (rst, synchronous): config to defaults, counters cleared, palette alpha valid bits
// cleared; the prior-row and palette colour memories are not cleared, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the PNG scanline unfilter. Byte stream in, RGBA pixels out.
// Instantiates png_unf_ctrl, png_unf_recon, png_unf_palette and png_unf_outq.
module png_scanline_unfilter_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // Configuration write port.
  input  wire                                  cfg_we,
  input  wire  [png_unf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [png_unf_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input stream.
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // data_byte, palette_index, palette_red, palette_green, palette_blue, palette_alpha
  input  wire  [png_unf_pkg::IN_TDATA_W-1:0]   s_tdata,
  // operation
  input  wire                                  s_tuser,
  // Output stream.
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // red, green, blue, alpha, pixel_column, pixel_row, zero padding
  output logic [png_unf_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // row_unsupported
  output logic                                 m_tuser,
  // last_pixel
  output logic                                 m_tlast
);

  localparam int STORE_DEPTH = 4 * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  logic                     accept;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  png_unf_pkg::byte_stage_t stage_q;
  logic [ADDR_W-1:0]        stage_addr;
  png_unf_pkg::pix_stage_t  pix_q;
  logic                     pal_rd_en;
  logic [7:0]               pal_rd_index;
  png_unf_pkg::pal_write_t  pal_wr;
  logic                     push;
  png_unf_pkg::out_word_t   push_word;
  logic [png_unf_pkg::OUTQ_CNT_W-1:0] q_count;
  logic [png_unf_pkg::OUTQ_CNT_W:0]   claimed;

  // Every word that will reach the queue already holds a slot: the words in it, the
  // pixel leaving reconstruction and the pixel waiting for its palette lookup.
  assign claimed = {1'b0, q_count}
                 + (png_unf_pkg::OUTQ_CNT_W + 1)'(stage_q.valid && stage_q.pix_done)
                 + (png_unf_pkg::OUTQ_CNT_W + 1)'(pix_q.valid);
  assign s_tready = claimed < (png_unf_pkg::OUTQ_CNT_W + 1)'(png_unf_pkg::OUTQ_DEPTH);
  assign accept   = s_tvalid && s_tready;

  // Palette writes go straight into the palette memories on acceptance. A pixel read
  // issued on the same edge sees the old entry, which keeps stream order.
  assign pal_wr.we    = accept && (s_tuser == png_unf_pkg::OP_PALETTE);
  assign pal_wr.index = s_tdata[15:8];
  assign pal_wr.color = {s_tdata[39:32], s_tdata[31:24], s_tdata[23:16]};
  assign pal_wr.alpha = s_tdata[47:40];

  png_unf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .op         (s_tuser),
    .data_byte  (s_tdata[7:0]),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .stage_q    (stage_q),
    .stage_addr (stage_addr)
  );

  png_unf_recon #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_recon (
    .clk          (clk),
    .rst          (rst),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .stage        (stage_q),
    .stage_addr   (stage_addr),
    .pix_q        (pix_q),
    .pal_rd_en    (pal_rd_en),
    .pal_rd_index (pal_rd_index)
  );

  png_unf_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .pal_wr    (pal_wr),
    .rd_en     (pal_rd_en),
    .rd_index  (pal_rd_index),
    .pix       (pix_q),
    .push      (push),
    .push_word (push_word)
  );

  png_unf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .count     (q_count)
  );

endmodule

`default_nettype wire
